### src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: word layouts,
// operation and status codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int PW       = 7;
  localparam int DW       = 32;
  localparam int WW       = ((PW > CW) ? PW : CW) + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_PUT,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                   operation;
    logic [PW-1:0]         position;
    logic signed [DW-1:0]  value;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic signed [DW-1:0]  element;
    logic [PW-1:0]         found_position;
    logic [PW-1:0]         length;
  } result_t;

  typedef struct packed {
    logic    load;
    logic    set_st;
    status_e st;
    logic    scan_init;
    logic    issue;
    logic    consume;
    logic    put_val;
    logic    cnt_inc;
    logic    cnt_dec;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic pos_zero;
    logic pos_gt_cnt;
    logic pos_gt_cnt1;
    logic full;
    logic cnt_zero;
    logic append;
    logic issue_last;
    logic lat_vld;
    logic match;
  } dp_sts_t;

endpackage

### src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the positional list engine: checks the word, steps the
// element memory scan and issues the result strobe.
// ----------------------------------------------------------------------------
module ple_ctrl
  import ple_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.pos_zero || sts_i.pos_gt_cnt1 || sts_i.full) begin
              state_d = S_RESP;
            end else if (sts_i.append) begin
              state_d = S_PUT;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_DELETE, OP_GET: begin
            if (sts_i.pos_zero || sts_i.pos_gt_cnt) begin
              state_d = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            if (sts_i.cnt_zero) begin
              state_d = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.op == OP_LOCATE && sts_i.match) begin
          state_d = S_RESP;
        end else if (sts_i.issue_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.op == OP_INSERT) begin
          state_d = S_PUT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_PUT:   state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    cmd_o.st = ST_OK;
    busy   = (state_q != S_IDLE);
    done_o = (state_q == S_RESP);
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_CHECK: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.pos_zero || sts_i.pos_gt_cnt1) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_RANGE;
            end else if (sts_i.full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_FULL;
            end else begin
              cmd_o.scan_init = !sts_i.append;
            end
          end
          OP_DELETE, OP_GET: begin
            if (sts_i.pos_zero || sts_i.pos_gt_cnt) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_RANGE;
            end else begin
              cmd_o.scan_init = 1'b1;
            end
          end
          default: begin
            cmd_o.set_st    = 1'b1;
            cmd_o.st        = ST_NOTFOUND;
            cmd_o.scan_init = !sts_i.cnt_zero;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.consume = sts_i.lat_vld;
        cmd_o.issue   = !(sts_i.op == OP_LOCATE && sts_i.match);
      end
      S_DRAIN: begin
        cmd_o.consume = sts_i.lat_vld;
        cmd_o.cnt_dec = (sts_i.op == OP_DELETE);
      end
      S_PUT: begin
        cmd_o.put_val = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Datapath for the positional list engine: element memory with registered
// read, scan pointer, element count and result registers.
// ----------------------------------------------------------------------------
module ple_dp
  import ple_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output result_t result_o
);

  logic [DW-1:0] mem_q [CAPACITY];

  op_e                  op_q;
  logic [PW-1:0]        pos_q;
  logic signed [DW-1:0] val_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        ptr_q;
  logic                 lat_vld_q;
  logic [AW-1:0]        lat_addr_q;
  logic [DW-1:0]        rdata_q;
  status_e              status_q;
  logic signed [DW-1:0] elem_q;
  logic [PW-1:0]        found_q;

  logic [WW-1:0]        pos_w, cnt_w, cnt_p1;
  logic [CW-1:0]        pos_m1, cnt_m1;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;
  logic                 match;
  logic                 head_hit;

  assign pos_w    = WW'(pos_q);
  assign cnt_w    = WW'(cnt_q);
  assign cnt_p1   = cnt_w + WW'(1);
  assign pos_m1   = CW'(pos_w - WW'(1));
  assign cnt_m1   = cnt_q - CW'(1);
  assign match    = lat_vld_q && (rdata_q == val_q);
  assign head_hit = (lat_addr_q == pos_m1[AW-1:0]);

  always_comb begin
    sts_o.op          = op_q;
    sts_o.pos_zero    = (pos_q == '0);
    sts_o.pos_gt_cnt  = (pos_w > cnt_w);
    sts_o.pos_gt_cnt1 = (pos_w > cnt_p1);
    sts_o.full        = (cnt_q == CW'(CAPACITY));
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.append      = (pos_w == cnt_p1);
    sts_o.lat_vld     = lat_vld_q;
    sts_o.match       = match;
    case (op_q)
      OP_INSERT: sts_o.issue_last = (ptr_q == pos_m1);
      OP_GET:    sts_o.issue_last = 1'b1;
      default:   sts_o.issue_last = (ptr_q == cnt_m1);
    endcase
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_m1[AW-1:0];
    wr_data = val_q;
    if (cmd_i.put_val) begin
      wr_en = 1'b1;
    end else if (cmd_i.consume) begin
      case (op_q)
        OP_INSERT: begin
          wr_en   = 1'b1;
          wr_addr = lat_addr_q + AW'(1);
          wr_data = rdata_q;
        end
        OP_DELETE: begin
          wr_en   = !head_hit;
          wr_addr = lat_addr_q - AW'(1);
          wr_data = rdata_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem_q[ptr_q[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      lat_vld_q <= 1'b0;
    end else begin
      lat_vld_q <= cmd_i.issue;
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_m1;
      end
    end
  end

  // word and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= item_i.operation;
      pos_q <= item_i.position;
      val_q <= item_i.value;
    end
    if (cmd_i.scan_init) begin
      case (op_q)
        OP_INSERT: ptr_q <= cnt_m1;
        OP_LOCATE: ptr_q <= '0;
        default:   ptr_q <= pos_m1;
      endcase
    end else if (cmd_i.issue) begin
      if (op_q == OP_INSERT) begin
        ptr_q <= ptr_q - CW'(1);
      end else begin
        ptr_q <= ptr_q + CW'(1);
      end
    end
    if (cmd_i.issue) begin
      lat_addr_q <= ptr_q[AW-1:0];
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= ST_OK;
      elem_q   <= '0;
      found_q  <= '0;
    end else begin
      if (cmd_i.set_st) begin
        status_q <= cmd_i.st;
      end
      if (cmd_i.consume) begin
        case (op_q)
          OP_GET: elem_q <= rdata_q;
          OP_DELETE: begin
            if (head_hit) begin
              elem_q <= rdata_q;
            end
          end
          OP_LOCATE: begin
            if (match) begin
              status_q <= ST_OK;
              found_q  <= PW'(CW'(lat_addr_q) + CW'(1));
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result_o.status         = status_q;
    result_o.element        = elem_q;
    result_o.found_position = found_q;
    result_o.length         = PW'(cnt_q);
  end

endmodule

### src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed 32-bit elements with positional
// insert, delete, get and locate by value. A word is taken when start is
// high and busy is low; busy stays high until the result has been shown.
// Rejected positions and a full store are answered without a scan;
// inserts, deletes and locates walk the element memory one entry per
// cycle, so the time grows with the number of entries moved or searched.
// The result sits on result_o for exactly one cycle with done_o high and
// cannot be held off; it must be captured in that cycle.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ple_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule
